// ----- hdl/fixed_point_math_unit_macros.svh -----
// fixed_point_math_unit_macros.svh: assertion macros for the fixed point math unit
// used by the top level; expects clk and rst_n in the including scope
`ifndef FIXED_POINT_MATH_UNIT_MACROS_SVH
`define FIXED_POINT_MATH_UNIT_MACROS_SVH

// condition in this cycle implies consequence in this cycle
`define FPMU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpmu assertion failed");

// condition in this cycle implies consequence in the next cycle
`define FPMU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpmu assertion failed");

`endif

// ----- hdl/fpmu_pkg.sv -----
// fpmu_pkg.sv: shared constants, codes and controller/datapath interface types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fpmu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int DVD_W     = WORD_BITS + FRAC_BITS;
    localparam int CNT_W     = $clog2(DVD_W);
    localparam int TOL_W     = 16;
    localparam int CAP_W     = 8;

    // request types
    localparam logic [2:0] OP_MUL  = 3'd0;
    localparam logic [2:0] OP_DIV  = 3'd1;
    localparam logic [2:0] OP_ABS  = 3'd2;
    localparam logic [2:0] OP_FLT  = 3'd3;
    localparam logic [2:0] OP_SQRT = 3'd4;
    localparam logic [2:0] OP_CBRT = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;
    localparam logic [1:0] ST_NOCONV  = 2'd3;

    // register indexes
    localparam logic REG_TOL = 1'b0;
    localparam logic REG_CAP = 1'b1;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd6;
    localparam logic [CAP_W-1:0] CAP_RESET = 8'd64;

    typedef enum logic [2:0] {
        RES_PROD     = 3'd0,
        RES_DIV      = 3'd1,
        RES_ABS      = 3'd2,
        RES_FLT      = 3'd3,
        RES_T_OK     = 3'd4,
        RES_T_NOCONV = 3'd5,
        RES_ZERO     = 3'd6
    } res_sel_t;

    typedef enum logic {
        DSEL_QUOT  = 1'b0,
        DSEL_THIRD = 1'b1
    } dsel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        logic     div_start;
        dsel_t    dsel;
        logic     div_step;
        logic     qs_save;
        logic     diff_save;
        logic     half_save;
        logic     third_save;
        logic     t_update;
        logic     res_load;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic conv;
        logic last_iter;
    } sts_t;

    // magnitude of a signed word, minimum maps to 2^31
    function automatic logic [WORD_BITS-1:0] mag32(input logic signed [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] r;
        r = v[WORD_BITS-1] ? WORD_BITS'(-v) : WORD_BITS'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/fpmu_ctrl.sv -----
// fpmu_ctrl.sv: sequencing state machine for the fixed point math unit
// depends on fpmu_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpmu_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [2:0]    req_type,
    output logic               out_valid,
    input  wire logic          out_ready,
    output fpmu_pkg::cmd_t     cmd,
    input  wire fpmu_pkg::sts_t sts
);
    import fpmu_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_MUL    = 12'b000000000010,
        S_DSTART = 12'b000000000100,
        S_DIV    = 12'b000000001000,
        S_QSAVE  = 12'b000000010000,
        S_DIFF   = 12'b000000100000,
        S_HALF   = 12'b000001000000,
        S_TSTART = 12'b000010000000,
        S_TSAVE  = 12'b000100000000,
        S_UPD    = 12'b001000000000,
        S_CHK    = 12'b010000000000,
        S_DONE   = 12'b100000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] op_reg, op_next;
    res_sel_t   sel_reg, sel_next;
    logic       ovalid_reg, ovalid_next;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_MUL;
            sel_reg    <= RES_ZERO;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            sel_reg    <= sel_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        sel_next    = sel_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        cmd.dsel    = DSEL_QUOT;
        cmd.res_sel = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    op_next  = req_type;
                    case (req_type)
                        OP_MUL:
                        begin
                            state_next = S_MUL;
                            sel_next   = RES_PROD;
                        end
                        OP_DIV:  state_next = S_DSTART;
                        OP_ABS:
                        begin
                            state_next = S_DONE;
                            sel_next   = RES_ABS;
                        end
                        OP_FLT:
                        begin
                            state_next = S_DONE;
                            sel_next   = RES_FLT;
                        end
                        OP_SQRT: state_next = S_DSTART;
                        OP_CBRT: state_next = S_MUL;
                        default:
                        begin
                            state_next = S_DONE;
                            sel_next   = RES_ZERO;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = (op_reg == OP_MUL) ? S_DONE : S_DSTART;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_QSAVE;
            end
            S_QSAVE:
            begin
                cmd.qs_save = 1'b1;
                if (op_reg == OP_DIV)
                begin
                    state_next = S_DONE;
                    sel_next   = RES_DIV;
                end
                else
                    state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff_save = 1'b1;
                state_next    = (op_reg == OP_CBRT) ? S_TSTART : S_HALF;
            end
            S_HALF:
            begin
                cmd.half_save = 1'b1;
                state_next    = S_UPD;
            end
            S_TSTART:
            begin
                // reciprocal multiply for the division by three
                cmd.div_start = 1'b1;
                cmd.dsel      = DSEL_THIRD;
                state_next    = S_TSAVE;
            end
            S_TSAVE:
            begin
                cmd.third_save = 1'b1;
                state_next     = S_UPD;
            end
            S_UPD:
            begin
                cmd.t_update = 1'b1;
                state_next   = S_CHK;
            end
            S_CHK:
            begin
                if (sts.conv)
                begin
                    state_next = S_DONE;
                    sel_next   = RES_T_OK;
                end
                else if (sts.last_iter)
                begin
                    state_next = S_DONE;
                    sel_next   = RES_T_NOCONV;
                end
                else
                    state_next = (op_reg == OP_CBRT) ? S_MUL : S_DSTART;
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!ovalid_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/fpmu_dp.sv -----
// fpmu_dp.sv: datapath with multiplier, serial restoring divider, root update
// and config registers; depends on fpmu_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpmu_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fpmu_pkg::cmd_t       cmd,
    output fpmu_pkg::sts_t            sts,
    input  wire logic [2:0]           req_type,
    input  wire logic signed [31:0]   operand_a,
    input  wire logic signed [31:0]   operand_b,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [15:0]          cfg_data,
    output logic signed [31:0]        result_value,
    output logic [1:0]                status
);
    import fpmu_pkg::*;

    localparam logic [WORD_BITS-1:0] LIM_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] LIM_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
    // ceil(2^33 / 3), exact floor(x / 3) for any 32-bit x after a shift by 33
    localparam logic [WORD_BITS-1:0] THIRD_RECIP = 32'haaaa_aaab;

    logic [TOL_W-1:0] tol_reg;
    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] iter_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [2:0]                  op_reg;
    logic signed [WORD_BITS-1:0] a_reg, b_reg, t_reg;
    logic signed [63:0]          prod_reg;
    logic [DVD_W-1:0]            dvd_reg, quo_reg;
    logic [WORD_BITS-1:0]        dvs_reg, rem_reg;
    logic                        neg_reg, zf_reg;
    logic signed [WORD_BITS-1:0] qs_reg;
    logic                        qsat_reg;
    logic signed [WORD_BITS:0]   d_reg;
    logic [2*WORD_BITS-1:0]      tprod_reg;
    logic                        tneg_reg;
    logic signed [WORD_BITS-1:0] dt_reg;
    logic                        conv_reg;
    logic signed [WORD_BITS-1:0] res_reg;
    logic [1:0]                  st_reg;

    // config registers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg  <= TOL_RESET;
            cap_reg  <= CAP_RESET;
            iter_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_TOL)
                tol_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_CAP)
                cap_reg <= cfg_data[CAP_W-1:0];
            if (cmd.load)
                iter_reg <= '0;
            else if (cmd.t_update)
                iter_reg <= iter_reg + 1'b1;
            if (cmd.div_start)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // multiplier operands
    logic signed [WORD_BITS-1:0] mul_x, mul_y;
    assign mul_x = (op_reg == OP_MUL) ? a_reg : t_reg;
    assign mul_y = (op_reg == OP_MUL) ? b_reg : t_reg;

    // divider start values; the newton difference magnitude fits in a word
    logic signed [WORD_BITS-1:0] den;
    logic [WORD_BITS-1:0]        dmag;
    always_comb
    begin
        case (op_reg)
            OP_DIV:  den = b_reg;
            OP_CBRT: den = prod_reg[DVD_W-1:FRAC_BITS];
            default: den = t_reg;
        endcase
        dmag = d_reg[WORD_BITS] ? WORD_BITS'(-d_reg) : WORD_BITS'(d_reg);
    end

    // one restoring step
    logic [WORD_BITS:0] rem_w;
    logic               take;
    assign rem_w = {rem_reg, dvd_reg[DVD_W-1]};
    assign take  = (rem_w >= {1'b0, dvs_reg});

    // quotient saturation and sign
    logic [WORD_BITS-1:0]        qlim, qmag;
    logic                        qsat;
    logic signed [WORD_BITS-1:0] qs;
    always_comb
    begin
        qlim = neg_reg ? LIM_NEG : LIM_POS;
        qsat = (quo_reg > {{(DVD_W-WORD_BITS){1'b0}}, qlim});
        qmag = qsat ? qlim : quo_reg[WORD_BITS-1:0];
        qs   = neg_reg ? WORD_BITS'(-qmag) : WORD_BITS'(qmag);
    end

    // halving toward zero, root update with saturation
    logic signed [WORD_BITS:0]   dh;
    logic signed [WORD_BITS+1:0] tsum;
    logic signed [WORD_BITS-1:0] t_sat;
    logic [WORD_BITS-1:0]        third;
    always_comb
    begin
        dh    = d_reg + {{WORD_BITS{1'b0}}, d_reg[WORD_BITS]};
        tsum  = {{2{t_reg[WORD_BITS-1]}}, t_reg} + {{2{dt_reg[WORD_BITS-1]}}, dt_reg};
        if (tsum > $signed({2'b00, LIM_POS}))
            t_sat = LIM_POS;
        else if (tsum < $signed({2'b11, LIM_NEG}))
            t_sat = LIM_NEG;
        else
            t_sat = tsum[WORD_BITS-1:0];
        third = {1'b0, tprod_reg[2*WORD_BITS-1:WORD_BITS+1]};
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= req_type;
            a_reg  <= operand_a;
            b_reg  <= operand_b;
            t_reg  <= WORD_BITS'(2) << FRAC_BITS;
        end
        if (cmd.mul_en)
            prod_reg <= mul_x * mul_y;
        if (cmd.div_start && cmd.dsel == DSEL_THIRD)
        begin
            tprod_reg <= dmag * THIRD_RECIP;
            tneg_reg  <= d_reg[WORD_BITS];
        end
        else if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            dvd_reg <= {mag32(a_reg), {FRAC_BITS{1'b0}}};
            dvs_reg <= mag32(den);
            neg_reg <= a_reg[WORD_BITS-1] ^ den[WORD_BITS-1];
            zf_reg  <= (den == '0);
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= take ? WORD_BITS'(rem_w - {1'b0, dvs_reg}) : rem_w[WORD_BITS-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], take};
        end
        if (cmd.qs_save)
        begin
            qs_reg   <= zf_reg ? '0 : qs;
            qsat_reg <= qsat && !zf_reg;
        end
        if (cmd.diff_save)
            d_reg <= {qs_reg[WORD_BITS-1], qs_reg} - {t_reg[WORD_BITS-1], t_reg};
        if (cmd.half_save)
            dt_reg <= dh[WORD_BITS:1];
        if (cmd.third_save)
            dt_reg <= tneg_reg ? WORD_BITS'(-third) : WORD_BITS'(third);
        if (cmd.t_update)
        begin
            t_reg    <= t_sat;
            conv_reg <= (mag32(dt_reg) <= {{(WORD_BITS-TOL_W){1'b0}}, tol_reg});
        end
    end

    // status toward the controller
    logic [CAP_W-1:0] cap_eff;
    assign cap_eff       = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
    assign sts.div_done  = (cnt_reg == CNT_W'(DVD_W - 1));
    assign sts.conv      = conv_reg;
    assign sts.last_iter = (iter_reg >= cap_eff);

    // absolute value
    logic signed [WORD_BITS-1:0] abs_v;
    logic                        abs_sat;
    assign abs_sat = (a_reg == $signed(LIM_NEG));
    assign abs_v   = abs_sat ? LIM_POS : mag32(a_reg);

    // ieee single to fixed, truncating toward zero
    logic       f_neg;
    logic [7:0] f_e, f_lsh, f_rsh;
    logic [23:0] f_m;
    logic [WORD_BITS-1:0] f_v;
    logic       f_sat;
    logic signed [WORD_BITS-1:0] flt_v;
    always_comb
    begin
        f_neg = a_reg[31];
        f_e   = a_reg[30:23];
        f_m   = {1'b1, a_reg[22:0]};
        f_lsh = f_e - 8'd134;
        f_rsh = 8'd134 - f_e;
        f_v   = '0;
        f_sat = 1'b0;
        if (f_e == 8'd0)
            f_v = '0;
        else if (f_e == 8'd255 || f_e >= 8'd143)
            f_sat = 1'b1;
        else if (f_e >= 8'd134)
            f_v = WORD_BITS'({8'b0, f_m} << f_lsh[3:0]);
        else if (f_rsh < 8'd24)
            f_v = WORD_BITS'(f_m >> f_rsh[4:0]);
        else
            f_v = '0;
        if (f_neg ? (f_v > LIM_NEG) : (f_v > LIM_POS))
            f_sat = 1'b1;
        if (f_e == 8'd0)
            flt_v = '0;
        else if (f_sat)
            flt_v = f_neg ? LIM_NEG : LIM_POS;
        else
            flt_v = f_neg ? WORD_BITS'(-f_v) : WORD_BITS'(f_v);
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                RES_PROD:
                begin
                    res_reg <= prod_reg[DVD_W-1:FRAC_BITS];
                    st_reg  <= ST_OK;
                end
                RES_DIV:
                begin
                    res_reg <= qs_reg;
                    st_reg  <= zf_reg ? ST_DIVZERO : (qsat_reg ? ST_SAT : ST_OK);
                end
                RES_ABS:
                begin
                    res_reg <= abs_v;
                    st_reg  <= abs_sat ? ST_SAT : ST_OK;
                end
                RES_FLT:
                begin
                    res_reg <= flt_v;
                    st_reg  <= (f_sat && f_e != 8'd0) ? ST_SAT : ST_OK;
                end
                RES_T_OK:
                begin
                    res_reg <= t_reg;
                    st_reg  <= ST_OK;
                end
                RES_T_NOCONV:
                begin
                    res_reg <= t_reg;
                    st_reg  <= ST_NOCONV;
                end
                default:
                begin
                    res_reg <= '0;
                    st_reg  <= ST_OK;
                end
            endcase
        end
    end

    assign result_value = res_reg;
    assign status       = st_reg;

endmodule

`default_nettype wire

// ----- hdl/fixed_point_math_unit.sv -----
// mul, abs, float and unknown requests bypass the divider; div makes one pass of the 48-step
// serial restoring divider; sqrt and cube root make one divider pass per newton
// iteration, for up to iteration_cap iterations
// one request in flight; the next is taken once the result sits in the output register
// reset: async active low, tolerance 6, iteration_cap 64, no result pending
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_math_unit_macros.svh"

module fixed_point_math_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [2:0]          req_type,
    input  wire logic signed [31:0]  operand_a,
    input  wire logic signed [31:0]  operand_b,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [31:0]       result_value,
    output logic [1:0]               status,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_data
);
    import fpmu_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    fpmu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // arithmetic datapath
    fpmu_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req_type),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_value (result_value),
        .status       (status)
    );

    // checks
    `FPMU_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
    `FPMU_ASSERT_NOW(a_divzero_gives_zero, out_valid && status == ST_DIVZERO, result_value == '0)
    `FPMU_ASSERT_NOW(a_load_only_when_free, cmd.res_load, !out_valid || out_ready)

endmodule

`default_nettype wire

// ----- tb/sv/fpmu_checker.sv -----
// fpmu_checker.sv: watches the request and result channels of the fixed point math unit,
// predicts each result and compares it; depends on fpmu_pkg
`timescale 1ns / 1ps

module fpmu_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] result_value,
    input  logic [1:0]         status,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending_count,
    output int                 result_count
);
    import fpmu_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         st;
    } fx_result_t;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    fx_result_t        expected_results[$];
    logic [TOL_W-1:0]  tol_reg;
    logic [CAP_W-1:0]  cap_reg;

    function automatic longint mag64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // q16.16 product, bits 47..16 of the exact product
    function automatic longint fx_product(longint a, longint b);
        longint p;
        logic [63:0] pb;
        p = a * b;
        pb = p;
        return longint'($signed(pb[47:16]));
    endfunction

    // quotient with saturation; st updated on divide by zero or saturation
    function automatic longint fx_quotient(longint a, longint b, inout logic [1:0] st);
        longint unsigned q, lim;
        bit neg;
        if (b == 0)
        begin
            st = ST_DIVZERO;
            return 0;
        end
        q = (longint'(mag64(a)) << FRAC_BITS) / mag64(b);
        neg = (a < 0) != (b < 0);
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (q > lim)
        begin
            q = lim;
            st = ST_SAT;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // ieee single bits to q16.16, truncating toward zero
    function automatic longint fx_from_single(logic [31:0] bits, inout logic [1:0] st);
        bit neg;
        int e, sh;
        longint unsigned m, v, lim;
        neg = bits[31];
        e = bits[30:23];
        m = {40'd0, 1'b1, bits[22:0]};
        sh = e - 127 - 23 + FRAC_BITS;
        if (e == 0)
            return 0;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (e == 255 || sh > 39)
        begin
            st = ST_SAT;
            return neg ? WORD_MIN : WORD_MAX;
        end
        if (sh >= 0)
            v = m << sh;
        else if (-sh >= 64)
            v = 0;
        else
            v = m >> (-sh);
        if (v > lim)
        begin
            st = ST_SAT;
            v = lim;
        end
        return neg ? -longint'(v) : longint'(v);
    endfunction

    // newton root from 2.0, square or cube
    function automatic longint fx_newton_root(longint x, bit cube, inout logic [1:0] st);
        longint t, dt;
        int cap;
        logic [1:0] inner;
        t = 64'sd2 << FRAC_BITS;
        cap = (cap_reg == 0) ? 1 : cap_reg;
        for (int i = 0; i < cap; i++)
        begin
            inner = ST_OK;
            if (cube)
                dt = (fx_quotient(x, fx_product(t, t), inner) - t) / 3;
            else
                dt = (fx_quotient(x, t, inner) - t) / 2;
            t = t + dt;
            if (t > WORD_MAX) t = WORD_MAX;
            if (t < WORD_MIN) t = WORD_MIN;
            if (mag64(dt) <= longint'(tol_reg))
                return t;
        end
        st = ST_NOCONV;
        return t;
    endfunction

    function automatic fx_result_t predict_result(logic [2:0] op, logic signed [31:0] a,
                                                  logic signed [31:0] b);
        fx_result_t res;
        longint r;
        logic [1:0] st;
        st = ST_OK;
        r = 0;
        case (op)
            OP_MUL:  r = fx_product(a, b);
            OP_DIV:  r = fx_quotient(a, b, st);
            OP_ABS:
            begin
                if (longint'(a) == WORD_MIN)
                begin
                    r = WORD_MAX;
                    st = ST_SAT;
                end
                else
                    r = mag64(a);
            end
            OP_FLT:  r = fx_from_single(a, st);
            OP_SQRT: r = fx_newton_root(a, 1'b0, st);
            OP_CBRT: r = fx_newton_root(a, 1'b1, st);
            default: r = 0;
        endcase
        res.value = r[31:0];
        res.st = st;
        return res;
    endfunction

    assign pending_count = expected_results.size();

    // track registers, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        fx_result_t exp_res;
        if (!rst_n)
        begin
            tol_reg = TOL_RESET;
            cap_reg = CAP_RESET;
            expected_results.delete();
            fail_count = 0;
            result_count = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_result(req_type, operand_a, operand_b));
            if (out_valid && out_ready)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result value=%h status=%0d",
                             $time, result_value, status);
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (result_value !== exp_res.value)
                    begin
                        fail_count++;
                        $display("%0t: result_value mismatch expected %h actual %h",
                                 $time, exp_res.value, result_value);
                    end
                    if (status !== exp_res.st)
                    begin
                        fail_count++;
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, exp_res.st, status);
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_TOL)
                    tol_reg = cfg_data;
                else
                    cap_reg = cfg_data[CAP_W-1:0];
            end
        end
    end
endmodule

// ----- tb/sv/tb_fixed_point_math_unit.sv -----
// tb_fixed_point_math_unit.sv: stimulus and verdict for the fixed point math unit
// depends on fpmu_pkg, fpmu_checker and the unit itself
`timescale 1ns / 1ps

module tb_fixed_point_math_unit;
    import fpmu_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         req_type = OP_MUL;
    logic signed [31:0] operand_a = '0;
    logic signed [31:0] operand_b = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic               cfg_we = 1'b0;
    logic               cfg_index = REG_TOL;
    logic [15:0]        cfg_data = '0;
    int                 fail_count, pending_count, result_count;
    bit                 no_idle = 0;

    always #5 clk = ~clk;

    fixed_point_math_unit dut (.*);

    fpmu_checker checker_i (.*);

    // result side stalls at random
    always @(posedge clk)
    begin
        int w;
        if (!rst_n)
            out_ready <= 1'b0;
        else if (out_valid && out_ready)
        begin
            w = no_idle ? 0 : $urandom_range(0, 16);
            if (w == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
        else
            out_ready <= 1'b1;
    end

    // valid drops only when an idle gap follows, so back to back requests keep it high
    task automatic send_request(logic [2:0] op, logic [31:0] a, logic [31:0] b);
        int w;
        w = no_idle ? 0 : $urandom_range(0, 16);
        if (w > 0)
        begin
            in_valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= op;
        operand_a <= a;
        operand_b <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        wait (pending_count == 0);
        repeat (20000) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random operand biased toward small magnitudes and edge values
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0008_0000);
            2: return -$urandom_range(0, 32'h0008_0000);
            3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            4: return $urandom_range(0, 255);
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [31:0] rand_single();
        logic [31:0] f;
        f = $urandom();
        case ($urandom_range(0, 3))
            0: f[30:23] = 8'($urandom_range(100, 160));
            1: f[30:23] = $urandom_range(0, 1) ? 8'd0 : 8'd255;
            default: ;
        endcase
        return f;
    endfunction

    task automatic random_phase(int n);
        logic [2:0] op;
        for (int i = 0; i < n; i++)
        begin
            no_idle = (i % 100) < 20;
            op = $urandom_range(0, 19) == 0 ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
            if (op == OP_FLT)
                send_request(op, rand_single(), $urandom());
            else if (op == OP_SQRT || op == OP_CBRT)
                send_request(op, $urandom_range(0, 7) == 0 ? $urandom() : rand_operand(),
                             $urandom());
            else
                send_request(op, rand_operand(), rand_operand());
        end
        in_valid <= 1'b0;
        no_idle = 0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: every operation and the named corner cases
        send_request(OP_MUL, 32'h7fff_ffff, 32'h8000_0000);
        send_request(OP_MUL, 32'h0001_8000, 32'hfffe_0000);
        send_request(OP_DIV, 32'h0003_0000, 32'h0000_0000);
        send_request(OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
        send_request(OP_DIV, 32'h8000_0000, 32'h0000_0001);
        send_request(OP_DIV, 32'hfff9_0000, 32'h0002_0000);
        send_request(OP_ABS, 32'h8000_0000, 32'h0);
        send_request(OP_ABS, 32'hffff_ffff, 32'h0);
        send_request(OP_ABS, 32'h7fff_ffff, 32'h0);
        send_request(OP_FLT, 32'h0000_0000, 32'h0);
        send_request(OP_FLT, 32'h0000_0001, 32'h0);
        send_request(OP_FLT, 32'h7f80_0000, 32'h0);
        send_request(OP_FLT, 32'hffc0_0000, 32'h0);
        send_request(OP_FLT, 32'h4f00_0000, 32'h0);
        send_request(OP_FLT, 32'hcf00_0000, 32'h0);
        send_request(OP_FLT, 32'hc0490fdb, 32'h0);
        send_request(OP_SQRT, 32'h0004_0000, 32'h0);
        send_request(OP_SQRT, 32'h0000_0000, 32'h0);
        send_request(OP_SQRT, 32'hfffc_0000, 32'h0);
        send_request(OP_SQRT, 32'h7fff_ffff, 32'h0);
        send_request(OP_CBRT, 32'h001b_0000, 32'h0);
        send_request(OP_CBRT, 32'hfff8_0000, 32'h0);
        send_request(3'd6, 32'h1234_5678, 32'h9abc_def0);
        send_request(3'd7, 32'hffff_ffff, 32'hffff_ffff);
        random_phase(250);
        // extremes of both registers, including a cap of zero
        write_reg(REG_TOL, 16'hffff);
        write_reg(REG_CAP, 16'h0000);
        random_phase(80);
        write_reg(REG_TOL, 16'h0000);
        write_reg(REG_CAP, 16'h00ff);
        random_phase(80);
        write_reg(REG_TOL, 16'h0100);
        write_reg(REG_CAP, 16'h0003);
        random_phase(100);
        write_reg(REG_TOL, 16'd6);
        write_reg(REG_CAP, 16'h0001);
        random_phase(90);
        wait (pending_count == 0);
        repeat (200) @(posedge clk);
        $display("covered %0d results over all request types and five register settings",
                 result_count);
        if (fail_count == 0)
            $display("** fixed_point_math_unit: PASSED **");
        else
            $display("** fixed_point_math_unit: FAILED **");
        $finish;
    end

    // timeout
    initial
    begin
        #400ms;
        $display("** fixed_point_math_unit: FAILED **");
        $finish;
    end
endmodule
